/* rtl/angle_gyro_kalman_filter_unit_macros.svh */
// Assertion macros shared by the angle and gyro bias filter RTL.
// Depends on nothing; files that assert include it by bare file name.
`ifndef ANGLE_GYRO_KALMAN_FILTER_UNIT_MACROS_SVH
`define ANGLE_GYRO_KALMAN_FILTER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define AGKF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("agkf assertion failed");
`define AGKF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("agkf assertion failed");
`else
`define AGKF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define AGKF_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/agkf_pkg.sv */
// Types, constants and saturating arithmetic helpers for the angle filter.
// Used by the multiplier, the divider and the top level; depends on nothing.
`default_nettype none
package agkf_pkg;
	localparam int FRAC_BITS = 24;
	localparam int VAL_W = 48;
	localparam int REG_W = 32;
	localparam int REG_IDX_W = 2;
	localparam int IN_W = 2 * VAL_W;
	localparam int OUT_W = 3 * VAL_W;

	localparam int MUL_CHUNK = 16;
	localparam int MUL_STEPS = VAL_W / MUL_CHUNK;
	localparam int MUL_CNT_W = $clog2(MUL_STEPS);
	localparam int PROD_W = 2 * VAL_W;

	localparam int DVD_W = VAL_W + FRAC_BITS;
	localparam int DIV_CNT_W = $clog2(DVD_W);

	localparam int Q30_SHIFT = 30 - FRAC_BITS;

	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic [VAL_W-1:0] mag_t;
	typedef logic [REG_W-1:0] reg_t;

	typedef struct packed {
		logic clip;
		val_t val;
	} sres_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic clip;
		val_t val;
	} unit_res_t;

	localparam logic [REG_IDX_W-1:0] REG_QA = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_QB = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_R = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_DT = 2'd3;

	localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
	localparam mag_t MAG_POS = {1'b0, {(VAL_W-1){1'b1}}};
	localparam mag_t MAG_NEG = {1'b1, {(VAL_W-1){1'b0}}};
	localparam val_t VAL_ONE = {{(VAL_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

	function automatic reg_t from_q30(input reg_t v);
		logic [REG_W:0] half;
		logic [REG_W:0] t;
		half = ((REG_W+1)'(1) << Q30_SHIFT) >> 1;
		t = ({1'b0, v} + half) >> Q30_SHIFT;
		return t[REG_W-1:0];
	endfunction

	localparam reg_t RST_QA = from_q30(32'd1073742);
	localparam reg_t RST_QB = from_q30(32'd3221225);
	localparam reg_t RST_R = from_q30(32'd719407022);
	localparam reg_t RST_DT = from_q30(32'd5368709);

	function automatic val_t ext_reg(input reg_t r);
		return val_t'({{(VAL_W-REG_W){1'b0}}, r});
	endfunction

	function automatic mag_t mag(input val_t a);
		mag_t u;
		u = a;
		return a[VAL_W-1] ? (~u + 1'b1) : u;
	endfunction

	function automatic val_t apply_sign(input mag_t m, input logic neg);
		return neg ? val_t'(~m + 1'b1) : val_t'(m);
	endfunction

	function automatic sres_t sat_wide(input logic [VAL_W:0] s);
		sres_t r;
		r.clip = s[VAL_W] ^ s[VAL_W-1];
		if (r.clip) begin
			r.val = s[VAL_W] ? VAL_MIN : VAL_MAX;
		end else begin
			r.val = s[VAL_W-1:0];
		end
		return r;
	endfunction

	function automatic sres_t sadd(input val_t a, input val_t b);
		return sat_wide({a[VAL_W-1], a} + {b[VAL_W-1], b});
	endfunction

	function automatic sres_t ssub(input val_t a, input val_t b);
		return sat_wide({a[VAL_W-1], a} - {b[VAL_W-1], b});
	endfunction
endpackage
`default_nettype wire

/* rtl/agkf_mul.sv */
// Shared fixed-point multiplier: magnitude product in 16-bit slices, rounding and saturation.
// Depends on agkf_pkg.
`default_nettype none
module agkf_mul (
	input logic clk,
	input logic arst_n,
	input logic start,
	input agkf_pkg::val_t a,
	input agkf_pkg::val_t b,
	output agkf_pkg::unit_res_t res
);
	import agkf_pkg::*;

	localparam int Q_W = PROD_W + 1 - FRAC_BITS;
	localparam logic [PROD_W:0] RND_HALF = (PROD_W+1)'(1) << (FRAC_BITS - 1);

	mag_t x_q;
	mag_t y_q;
	logic neg_q;
	logic [PROD_W-1:0] acc_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic run_q;
	logic fin_q;
	logic done_q;
	logic clip_q;
	val_t val_q;

	logic [VAL_W+MUL_CHUNK-1:0] pp;
	logic [PROD_W-1:0] acc_nx;
	logic [PROD_W:0] rnd;
	logic [Q_W-1:0] qv;
	mag_t lim;
	logic over;
	mag_t mag_o;

	always_comb begin
		pp = x_q * y_q[MUL_CHUNK-1:0];
		acc_nx = (acc_q >> MUL_CHUNK) + {pp, {(VAL_W-MUL_CHUNK){1'b0}}};
		rnd = {1'b0, acc_q} + RND_HALF;
		qv = rnd[PROD_W:FRAC_BITS];
		lim = neg_q ? MAG_NEG : MAG_POS;
		over = qv > Q_W'(lim);
		mag_o = over ? lim : qv[VAL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= fin_q;
			fin_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == MUL_CNT_W'(MUL_STEPS - 1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= mag(a);
			y_q <= mag(b);
			neg_q <= a[VAL_W-1] ^ b[VAL_W-1];
			acc_q <= '0;
		end else if (run_q) begin
			acc_q <= acc_nx;
			y_q <= y_q >> MUL_CHUNK;
		end
		if (fin_q) begin
			val_q <= apply_sign(mag_o, neg_q);
			clip_q <= over;
		end
	end

	assign res.busy = run_q | fin_q;
	assign res.done = done_q;
	assign res.clip = clip_q;
	assign res.val = val_q;
endmodule
`default_nettype wire

/* rtl/agkf_div.sv */
// Shared fixed-point divider: restoring, one quotient bit per cycle, saturating result.
// Depends on agkf_pkg. The denominator must be positive.
`default_nettype none
module agkf_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input agkf_pkg::val_t num,
	input agkf_pkg::val_t den,
	output agkf_pkg::unit_res_t res
);
	import agkf_pkg::*;

	logic [DVD_W-1:0] dvd_q;
	mag_t rem_q;
	mag_t den_q;
	logic neg_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic run_q;
	logic fin_q;
	logic done_q;
	logic clip_q;
	val_t val_q;

	logic [VAL_W:0] r2;
	logic [VAL_W:0] diff;
	logic ge;
	mag_t lim;
	logic over;
	mag_t mag_o;

	always_comb begin
		r2 = {rem_q, dvd_q[DVD_W-1]};
		diff = r2 - {1'b0, den_q};
		ge = r2 >= {1'b0, den_q};
		lim = neg_q ? MAG_NEG : MAG_POS;
		over = dvd_q > DVD_W'(lim);
		mag_o = over ? lim : dvd_q[VAL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= fin_q;
			fin_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= DIV_CNT_W'(DVD_W - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {mag(num), {FRAC_BITS{1'b0}}};
			rem_q <= '0;
			den_q <= mag_t'(den);
			neg_q <= num[VAL_W-1];
		end else if (run_q) begin
			rem_q <= ge ? diff[VAL_W-1:0] : r2[VAL_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
		end
		if (fin_q) begin
			val_q <= apply_sign(mag_o, neg_q);
			clip_q <= over;
		end
	end

	assign res.busy = run_q | fin_q;
	assign res.done = done_q;
	assign res.clip = clip_q;
	assign res.val = val_q;
endmodule
`default_nettype wire

/* rtl/angle_gyro_kalman_filter_unit.sv */
// Top level of the angle and gyro bias filter: sequencer, filter state and stream ports.
// Depends on agkf_pkg, agkf_mul, agkf_div and the assertion macro header.
// An updated item passes through ten multiplications on the shared multiplier and
// two divisions on the bit-serial divider, which develops a 72-bit quotient.
// When the innovation variance is not positive the divisions and the update
// are skipped. The next item is accepted once the result is in the output
// register, even while that result still waits to be taken.
`default_nettype none
`include "angle_gyro_kalman_filter_unit_macros.svh"
module angle_gyro_kalman_filter_unit (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [agkf_pkg::REG_IDX_W-1:0] cfg_index,
	input agkf_pkg::reg_t cfg_data,
	input logic s_tvalid,
	output logic s_tready,
	// measured_angle [47:0], measured_rate [95:48]
	input logic [agkf_pkg::IN_W-1:0] s_tdata,
	output logic m_tvalid,
	input logic m_tready,
	// filtered_angle [47:0], filtered_rate [95:48], bias_estimate [143:96]
	output logic [agkf_pkg::OUT_W-1:0] m_tdata,
	// saturated [0]
	output logic m_tuser
);
	import agkf_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_M_ANG = 4'd1;
	localparam logic [3:0] ST_M_P00 = 4'd2;
	localparam logic [3:0] ST_M_P01 = 4'd3;
	localparam logic [3:0] ST_M_P11 = 4'd4;
	localparam logic [3:0] ST_ERR = 4'd5;
	localparam logic [3:0] ST_D_K0 = 4'd6;
	localparam logic [3:0] ST_D_K1 = 4'd7;
	localparam logic [3:0] ST_M_U00 = 4'd8;
	localparam logic [3:0] ST_M_U01 = 4'd9;
	localparam logic [3:0] ST_M_U10 = 4'd10;
	localparam logic [3:0] ST_M_U11 = 4'd11;
	localparam logic [3:0] ST_M_UA = 4'd12;
	localparam logic [3:0] ST_M_UB = 4'd13;
	localparam logic [3:0] ST_OUT = 4'd14;

	logic [3:0] state_q;
	logic [3:0] st_next;
	logic issued_q;
	logic clip_q;

	reg_t qa_q;
	reg_t qb_q;
	reg_t r_q;
	reg_t dt_q;

	val_t ang_q;
	val_t bias_q;
	val_t p00_q;
	val_t p01_q;
	val_t p10_q;
	val_t p11_q;

	val_t am_q;
	val_t gm_q;
	val_t err_q;
	val_t e_q;
	val_t t0_q;
	val_t t1_q;
	val_t k0_q;
	val_t k1_q;

	logic m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;
	logic m_tuser_q;

	logic mul_st;
	logic div_st;
	logic sub_op;
	logic mul_start;
	logic div_start;
	logic out_load;
	logic e_pos;
	val_t mul_a;
	val_t mul_b;
	val_t div_num;
	val_t tgt;
	logic op_clip;
	sres_t op1;
	sres_t op2;
	sres_t upd;
	sres_t upd10;
	sres_t err_r;
	sres_t e_r;
	sres_t rate_r;
	unit_res_t mul_res;
	unit_res_t div_res;

	agkf_mul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.start(mul_start),
		.a(mul_a),
		.b(mul_b),
		.res(mul_res)
	);

	agkf_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(div_num),
		.den(e_q),
		.res(div_res)
	);

	always_comb begin
		mul_st = 1'b0;
		div_st = 1'b0;
		sub_op = 1'b0;
		st_next = ST_IDLE;
		op1 = '0;
		op2 = '0;
		mul_a = '0;
		mul_b = ext_reg(dt_q);
		op_clip = 1'b0;
		tgt = ang_q;
		div_num = p00_q;
		unique case (state_q)
			ST_M_ANG: begin
				mul_st = 1'b1;
				st_next = ST_M_P00;
				op1 = ssub(gm_q, bias_q);
				mul_a = op1.val;
				op_clip = op1.clip;
			end
			ST_M_P00: begin
				mul_st = 1'b1;
				st_next = ST_M_P01;
				op1 = ssub(ext_reg(qa_q), p01_q);
				op2 = ssub(op1.val, p10_q);
				mul_a = op2.val;
				op_clip = op1.clip | op2.clip;
				tgt = p00_q;
			end
			ST_M_P01: begin
				mul_st = 1'b1;
				st_next = ST_M_P11;
				op1 = ssub('0, p11_q);
				mul_a = op1.val;
				op_clip = op1.clip;
				tgt = p01_q;
			end
			ST_M_P11: begin
				mul_st = 1'b1;
				st_next = ST_ERR;
				mul_a = ext_reg(qb_q);
				tgt = p11_q;
			end
			ST_D_K0: begin
				div_st = 1'b1;
				st_next = ST_D_K1;
			end
			ST_D_K1: begin
				div_st = 1'b1;
				st_next = ST_M_U00;
				div_num = p10_q;
			end
			ST_M_U00: begin
				mul_st = 1'b1;
				sub_op = 1'b1;
				st_next = ST_M_U01;
				mul_a = k0_q;
				mul_b = t0_q;
				tgt = p00_q;
			end
			ST_M_U01: begin
				mul_st = 1'b1;
				sub_op = 1'b1;
				st_next = ST_M_U10;
				mul_a = k0_q;
				mul_b = t1_q;
				tgt = p01_q;
			end
			ST_M_U10: begin
				mul_st = 1'b1;
				sub_op = 1'b1;
				st_next = ST_M_U11;
				mul_a = k1_q;
				mul_b = t0_q;
				tgt = p10_q;
			end
			ST_M_U11: begin
				mul_st = 1'b1;
				sub_op = 1'b1;
				st_next = ST_M_UA;
				mul_a = k1_q;
				mul_b = t1_q;
				tgt = p11_q;
			end
			ST_M_UA: begin
				mul_st = 1'b1;
				st_next = ST_M_UB;
				mul_a = k0_q;
				mul_b = err_q;
			end
			ST_M_UB: begin
				mul_st = 1'b1;
				st_next = ST_OUT;
				mul_a = k1_q;
				mul_b = err_q;
				tgt = bias_q;
			end
			default: begin
				st_next = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		mul_start = mul_st & ~issued_q;
		div_start = div_st & ~issued_q;
		upd = sub_op ? ssub(tgt, mul_res.val) : sadd(tgt, mul_res.val);
		upd10 = sadd(p10_q, mul_res.val);
		err_r = ssub(am_q, ang_q);
		e_r = sadd(ext_reg(r_q), p00_q);
		e_pos = ~e_r.val[VAL_W-1] & (e_r.val != '0);
		rate_r = ssub(gm_q, bias_q);
		out_load = (state_q == ST_OUT) & (~m_tvalid_q | m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			issued_q <= 1'b0;
			clip_q <= 1'b0;
			qa_q <= RST_QA;
			qb_q <= RST_QB;
			r_q <= RST_R;
			dt_q <= RST_DT;
			ang_q <= '0;
			bias_q <= '0;
			p00_q <= VAL_ONE;
			p01_q <= '0;
			p10_q <= '0;
			p11_q <= VAL_ONE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_QA: qa_q <= cfg_data;
					REG_QB: qb_q <= cfg_data;
					REG_R: r_q <= cfg_data;
					REG_DT: dt_q <= cfg_data;
				endcase
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						clip_q <= 1'b0;
						state_q <= ST_M_ANG;
					end
				end
				ST_ERR: begin
					clip_q <= clip_q | err_r.clip | e_r.clip | ~e_pos;
					state_q <= e_pos ? ST_D_K0 : ST_OUT;
				end
				ST_D_K0, ST_D_K1: begin
					if (div_start) begin
						issued_q <= 1'b1;
					end
					if (div_res.done) begin
						issued_q <= 1'b0;
						clip_q <= clip_q | div_res.clip;
						state_q <= st_next;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					if (mul_start) begin
						issued_q <= 1'b1;
						clip_q <= clip_q | op_clip;
					end
					if (mul_res.done) begin
						issued_q <= 1'b0;
						state_q <= st_next;
						clip_q <= clip_q | mul_res.clip | upd.clip |
							((state_q == ST_M_P01) & upd10.clip);
						unique case (state_q)
							ST_M_ANG, ST_M_UA: ang_q <= upd.val;
							ST_M_P00, ST_M_U00: p00_q <= upd.val;
							ST_M_P01: begin
								p01_q <= upd.val;
								p10_q <= upd10.val;
							end
							ST_M_U01: p01_q <= upd.val;
							ST_M_U10: p10_q <= upd.val;
							ST_M_P11, ST_M_U11: p11_q <= upd.val;
							ST_M_UB: bias_q <= upd.val;
							default: ang_q <= ang_q;
						endcase
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			am_q <= s_tdata[VAL_W-1:0];
			gm_q <= s_tdata[IN_W-1:VAL_W];
		end
		if (state_q == ST_ERR) begin
			err_q <= err_r.val;
			e_q <= e_r.val;
			t0_q <= p00_q;
			t1_q <= p01_q;
		end
		if (div_res.done) begin
			if (state_q == ST_D_K0) begin
				k0_q <= div_res.val;
			end else begin
				k1_q <= div_res.val;
			end
		end
		if (out_load) begin
			m_tdata_q <= {bias_q, rate_r.val, ang_q};
			m_tuser_q <= clip_q | rate_r.clip;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

	`AGKF_ASSERT_IMP(a_ready_units_idle, clk, arst_n, s_tready, !mul_res.busy && !div_res.busy)
	`AGKF_ASSERT_IMP(a_done_was_issued, clk, arst_n, mul_res.done || div_res.done, issued_q)
	`AGKF_ASSERT_NXT(a_skip_to_output, clk, arst_n, state_q == ST_ERR && !e_pos, state_q == ST_OUT && clip_q)
endmodule
`default_nettype wire

/* tb/tb_angle_gyro_kalman_filter_unit.sv */
// Self-checking testbench for the angle and gyro bias filter unit: streams sensor items
// through the block and checks every result against a fixed-point predictor kept here.
// Depends on agkf_pkg and angle_gyro_kalman_filter_unit.
`timescale 1ns / 100ps

class kalman_scoreboard;
	typedef struct {
		agkf_pkg::val_t angle;
		agkf_pkg::val_t rate;
		agkf_pkg::val_t bias;
		logic sat;
	} filter_out_t;

	localparam longint FRAC = agkf_pkg::FRAC_BITS;
	localparam longint HI = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint LO = -64'sh0000_8000_0000_0000;
	localparam longint ONE = 64'sd1 << FRAC;

	longint qa_reg, qb_reg, r_reg, dt_reg;
	longint angle_est, bias_est, p_aa, p_ab, p_ba, p_bb;
	bit clip;
	int errors;
	filter_out_t expected_outputs[$];

	function new();
		qa_reg = longint'(agkf_pkg::RST_QA);
		qb_reg = longint'(agkf_pkg::RST_QB);
		r_reg = longint'(agkf_pkg::RST_R);
		dt_reg = longint'(agkf_pkg::RST_DT);
		angle_est = 0;
		bias_est = 0;
		p_aa = ONE;
		p_ab = 0;
		p_ba = 0;
		p_bb = ONE;
		errors = 0;
	endfunction

	function int pending();
		return expected_outputs.size();
	endfunction

	function void write_reg(logic [agkf_pkg::REG_IDX_W-1:0] idx, agkf_pkg::reg_t data);
		case (idx)
			agkf_pkg::REG_QA: qa_reg = longint'(data);
			agkf_pkg::REG_QB: qb_reg = longint'(data);
			agkf_pkg::REG_R: r_reg = longint'(data);
			agkf_pkg::REG_DT: dt_reg = longint'(data);
			default: ;
		endcase
	endfunction

	function longint clamp(longint v);
		if (v > HI) begin
			clip = 1'b1;
			return HI;
		end
		if (v < LO) begin
			clip = 1'b1;
			return LO;
		end
		return v;
	endfunction

	function longint add_s(longint a, longint b);
		return clamp(a + b);
	endfunction

	function longint sub_s(longint a, longint b);
		return clamp(a - b);
	endfunction

	function logic [63:0] magnitude(longint a);
		return (a < 0) ? -a : a;
	endfunction

	function longint signed_limit(logic [127:0] m, bit neg);
		logic [127:0] lim;
		lim = neg ? (128'd1 << 47) : ((128'd1 << 47) - 128'd1);
		if (m > lim) begin
			clip = 1'b1;
			m = lim;
		end
		return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
	endfunction

	function longint mul_q(longint a, longint b);
		logic [127:0] p;
		p = 128'(magnitude(a)) * 128'(magnitude(b));
		p = (p + (128'd1 << (FRAC - 1))) >> FRAC;
		return signed_limit(p, (a < 0) != (b < 0));
	endfunction

	// The divisor is always positive here.
	function longint div_q(longint num, longint den);
		logic [127:0] q;
		q = (128'(magnitude(num)) << FRAC) / 128'(den);
		return signed_limit(q, num < 0);
	endfunction

	function void note_sample(agkf_pkg::val_t am_in, agkf_pkg::val_t gm_in);
		longint am, gm, pd0, pd1, err, e, k0, k1, t0, t1;
		filter_out_t x;
		am = am_in;
		gm = gm_in;
		clip = 1'b0;
		angle_est = add_s(angle_est, mul_q(sub_s(gm, bias_est), dt_reg));
		pd0 = sub_s(sub_s(qa_reg, p_ab), p_ba);
		pd1 = sub_s(0, p_bb);
		p_aa = add_s(p_aa, mul_q(pd0, dt_reg));
		p_ab = add_s(p_ab, mul_q(pd1, dt_reg));
		p_ba = add_s(p_ba, mul_q(pd1, dt_reg));
		p_bb = add_s(p_bb, mul_q(qb_reg, dt_reg));
		err = sub_s(am, angle_est);
		e = add_s(r_reg, p_aa);
		if (e <= 0) begin
			clip = 1'b1;
		end else begin
			k0 = div_q(p_aa, e);
			k1 = div_q(p_ba, e);
			t0 = p_aa;
			t1 = p_ab;
			p_aa = sub_s(p_aa, mul_q(k0, t0));
			p_ab = sub_s(p_ab, mul_q(k0, t1));
			p_ba = sub_s(p_ba, mul_q(k1, t0));
			p_bb = sub_s(p_bb, mul_q(k1, t1));
			angle_est = add_s(angle_est, mul_q(k0, err));
			bias_est = add_s(bias_est, mul_q(k1, err));
		end
		x.rate = agkf_pkg::val_t'(sub_s(gm, bias_est));
		x.angle = agkf_pkg::val_t'(angle_est);
		x.bias = agkf_pkg::val_t'(bias_est);
		x.sat = clip;
		expected_outputs.push_back(x);
	endfunction

	task report_mismatch(string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		errors++;
	endtask

	task check_output(agkf_pkg::val_t angle, agkf_pkg::val_t rate, agkf_pkg::val_t bias,
			logic sat);
		filter_out_t x;
		if (expected_outputs.size() == 0) begin
			report_mismatch("result arrived with no item outstanding");
		end else begin
			x = expected_outputs.pop_front();
			if (angle !== x.angle) begin
				report_mismatch($sformatf("filtered_angle %0d, expected %0d", angle, x.angle));
			end
			if (rate !== x.rate) begin
				report_mismatch($sformatf("filtered_rate %0d, expected %0d", rate, x.rate));
			end
			if (bias !== x.bias) begin
				report_mismatch($sformatf("bias_estimate %0d, expected %0d", bias, x.bias));
			end
			if (sat !== x.sat) begin
				report_mismatch($sformatf("saturated %0b, expected %0b", sat, x.sat));
			end
		end
	endtask
endclass

module tb_angle_gyro_kalman_filter_unit;
	import agkf_pkg::*;

	localparam longint Q_ONE = 64'sd1 << FRAC_BITS;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [REG_IDX_W-1:0] cfg_index;
	reg_t cfg_data;
	logic s_tvalid;
	logic s_tready;
	logic [IN_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_W-1:0] m_tdata;
	logic m_tuser;

	int send_idle;
	int recv_idle;
	longint walk_angle;
	longint gyro_offset;
	kalman_scoreboard sb;

	angle_gyro_kalman_filter_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(negedge clk) begin
		m_tready = ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_output(m_tdata[VAL_W-1:0], m_tdata[2*VAL_W-1:VAL_W],
				m_tdata[3*VAL_W-1:2*VAL_W], m_tuser);
		end
	end

	task wait_drained();
		while (sb.pending() != 0) begin
			@(negedge clk);
		end
		repeat (16) @(negedge clk);
	endtask

	task write_register(logic [REG_IDX_W-1:0] idx, reg_t data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task load_filter_settings(reg_t qa, reg_t qb, reg_t r, reg_t dt);
		wait_drained();
		write_register(REG_QA, qa);
		write_register(REG_QB, qb);
		write_register(REG_R, r);
		write_register(REG_DT, dt);
	endtask

	task send_sample(longint am, longint gm);
		while ($urandom_range(99) < send_idle) begin
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {val_t'(gm), val_t'(am)};
		do begin
			@(posedge clk);
		end while (!s_tready);
		sb.note_sample(val_t'(am), val_t'(gm));
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	function longint spread(int unsigned half_range);
		return longint'($urandom_range(2 * half_range)) - longint'(half_range);
	endfunction

	function longint any_value();
		return longint'(val_t'({$urandom, $urandom}));
	endfunction

	function longint corner_value();
		case ($urandom_range(4))
			0: return longint'(VAL_MAX);
			1: return longint'(VAL_MIN);
			2: return 0;
			3: return -1;
			default: return Q_ONE;
		endcase
	endfunction

	function reg_t pick_setting(logic [REG_IDX_W-1:0] idx, bit wild);
		if (wild) begin
			case ($urandom_range(5))
				0: return '0;
				1: return '1;
				2, 3: return $urandom;
				default: ;
			endcase
		end
		case (idx)
			REG_QA, REG_QB: return $urandom_range(1 << 18);
			REG_R: return $urandom_range(1 << 26, 1 << 20);
			default: return $urandom_range(1 << 20, 1 << 12);
		endcase
	endfunction

	// Mostly a plausible sensor track: a slowly walking angle with noise and a gyro
	// that carries a fixed offset, with a share of full-range and corner items.
	task run_random_items(int count);
		int sel;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(49) == 0) begin
				wait_drained();
			end
			sel = $urandom_range(99);
			if (sel < 80) begin
				walk_angle += spread(1 << 22);
				send_sample(walk_angle + spread(1 << 21),
					spread(1 << 26) + gyro_offset + spread(1 << 20));
			end else if (sel < 90) begin
				send_sample(any_value(), any_value());
			end else begin
				send_sample(corner_value(), corner_value());
			end
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_QA;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b1;
		send_idle = 0;
		recv_idle = 0;
		walk_angle = 0;
		gyro_offset = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_sample(0, 0);
		send_sample(Q_ONE, 0);
		send_sample(longint'(VAL_MAX), longint'(VAL_MAX));
		send_sample(longint'(VAL_MIN), longint'(VAL_MIN));
		send_sample(longint'(VAL_MAX), longint'(VAL_MIN));
		send_sample(longint'(VAL_MIN), longint'(VAL_MAX));
		send_sample(-1, 1);
		send_sample(0, 0);

		// With all settings zero the first item drives the angle variance to zero,
		// so the innovation variance of the following items is zero and the update
		// is skipped.
		load_filter_settings('0, '0, '0, '0);
		send_sample(Q_ONE, Q_ONE / 2);
		send_sample(-2 * Q_ONE, Q_ONE);
		send_sample(0, 0);

		load_filter_settings('1, '1, '1, '1);
		send_sample(longint'(VAL_MAX), longint'(VAL_MIN));
		send_sample(longint'(VAL_MIN), longint'(VAL_MAX));
		send_sample(longint'(VAL_MAX), longint'(VAL_MAX));
		send_sample(0, -1);
		send_sample(longint'(VAL_MIN), 0);

		load_filter_settings(reg_t'(16777), reg_t'(50332), reg_t'(11240735), reg_t'(83886));
		send_sample(Q_ONE, Q_ONE);
		send_sample(-Q_ONE, 0);

		for (int phase = 0; phase < 6; phase++) begin
			load_filter_settings(pick_setting(REG_QA, phase == 5),
				pick_setting(REG_QB, phase == 5), pick_setting(REG_R, phase == 5),
				pick_setting(REG_DT, phase == 5));
			if (phase < 2) begin
				send_idle = 32;
				recv_idle = 51;
			end else if (phase < 4) begin
				send_idle = 51;
				recv_idle = 32;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			gyro_offset = spread(1 << 22);
			run_random_items(130);
		end

		while (sb.pending() != 0) begin
			@(negedge clk);
		end
		repeat (300) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#(64'd18_000_000);
		$display("Verification failed");
		$finish;
	end
endmodule
